// ===== hdl/dav_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and register codes for the drag and acceleration velocity step.
package dav_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned PUSH_W     = 2;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned VEL_H_W    = 16;
  localparam int unsigned VEL_V_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAG_SHIFT     = 3'd0,
    REG_ACCEL_STEP     = 3'd1,
    REG_SPEED_LIMIT    = 3'd2,
    REG_FLOW_X         = 3'd3,
    REG_FLOW_Y         = 3'd4,
    REG_RISE_RATE      = 3'd5,
    REG_CEILING_ENABLE = 3'd6,
    REG_CEILING_LINE   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [3:0]  drag_shift;
    logic        [14:0] accel_step;
    logic        [14:0] speed_limit;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic signed [15:0] rise_rate;
    logic               ceiling_enable;
    logic signed [15:0] ceiling_line;
  } cfg_t;

endpackage

// ===== hdl/dav_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tick items and velocity results.
interface dav_in_if;
  import dav_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [PUSH_W-1:0] push_horizontal;
  logic signed [PUSH_W-1:0] push_vertical;
  logic signed [POS_W-1:0]  position_vertical;

  modport source (output valid, push_horizontal, push_vertical, position_vertical,
                  input ready);
  modport sink   (input valid, push_horizontal, push_vertical, position_vertical,
                  output ready);
endinterface

interface dav_out_if;
  import dav_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VEL_H_W-1:0] speed_horizontal;
  logic signed [VEL_V_W-1:0] speed_vertical;
  logic                      surfaced;
  logic                      at_ceiling;

  modport source (output valid, speed_horizontal, speed_vertical, surfaced, at_ceiling,
                  input ready);
  modport sink   (input valid, speed_horizontal, speed_vertical, surfaced, at_ceiling,
                  output ready);
endinterface

// ===== hdl/dav_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file with a plain indexed write port.
module dav_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dav_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dav_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output dav_pkg::cfg_t                    cfg_o
);
  import dav_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drag_shift     <= '0;
      cfg_q.accel_step     <= '0;
      cfg_q.speed_limit    <= '1;
      cfg_q.flow_x         <= '0;
      cfg_q.flow_y         <= '0;
      cfg_q.rise_rate      <= '0;
      cfg_q.ceiling_enable <= 1'b0;
      cfg_q.ceiling_line   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DRAG_SHIFT:     cfg_q.drag_shift     <= cfg_data_i[3:0];
        REG_ACCEL_STEP:     cfg_q.accel_step     <= cfg_data_i[14:0];
        REG_SPEED_LIMIT:    cfg_q.speed_limit    <= cfg_data_i[14:0];
        REG_FLOW_X:         cfg_q.flow_x         <= cfg_data_i;
        REG_FLOW_Y:         cfg_q.flow_y         <= cfg_data_i;
        REG_RISE_RATE:      cfg_q.rise_rate      <= cfg_data_i;
        REG_CEILING_ENABLE: cfg_q.ceiling_enable <= cfg_data_i[0];
        REG_CEILING_LINE:   cfg_q.ceiling_line   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/dav_axis.sv =====
`timescale 1ns / 1ps
// One axis: drag toward the current, push acceleration and magnitude clamp.
module dav_axis (
  input  logic signed [dav_pkg::VEL_V_W-1:0]  v_i,
  input  logic signed [dav_pkg::PUSH_W-1:0]   push_i,
  input  logic signed [15:0]                  current_i,
  input  dav_pkg::cfg_t                       cfg_i,
  output logic signed [dav_pkg::VEL_H_W-1:0]  v_o
);
  import dav_pkg::*;

  // 20 bits cover velocity minus current, plus current, plus accel.
  logic signed [19:0] gap;
  logic signed [19:0] span;
  logic signed [19:0] gap_drag;
  logic signed [19:0] accel;
  logic signed [19:0] lim;
  logic signed [19:0] v_sum;

  always_comb begin
    gap  = 20'(v_i) - 20'(current_i);
    span = 20'sd1 <<< cfg_i.drag_shift;
    gap_drag = gap;
    if (cfg_i.drag_shift != 4'd0) begin
      if ((gap < span) && (gap > -span)) begin
        gap_drag = '0;
      end else begin
        gap_drag = gap - (gap >>> cfg_i.drag_shift);
      end
    end

    accel = 20'(signed'({1'b0, cfg_i.accel_step}));
    lim   = 20'(signed'({1'b0, cfg_i.speed_limit}));
    v_sum = 20'(current_i) + gap_drag;
    // A pattern with the sign bit set counts as a negative push.
    if (push_i[1]) begin
      v_sum = v_sum - accel;
    end else if (push_i[0]) begin
      v_sum = v_sum + accel;
    end

    if (v_sum > lim) begin
      v_sum = lim;
    end else if (v_sum < -lim) begin
      v_sum = -lim;
    end
    v_o = v_sum[VEL_H_W-1:0];
  end

endmodule

// ===== hdl/dav_ceiling.sv =====
`timescale 1ns / 1ps
// Vertical rise and top line limit.
module dav_ceiling #(
  parameter int unsigned FRAC_BITS = dav_pkg::FRAC_BITS_DEF
) (
  input  logic signed [dav_pkg::VEL_H_W-1:0]  vy_axis_i,
  input  logic signed [dav_pkg::PUSH_W-1:0]   push_vertical_i,
  input  logic signed [dav_pkg::POS_W-1:0]    position_vertical_i,
  input  dav_pkg::cfg_t                       cfg_i,
  output logic signed [dav_pkg::VEL_V_W-1:0]  vy_o,
  output logic                                surfaced_o,
  output logic                                at_ceiling_o
);
  import dav_pkg::*;

  // Room in fixed point needs the 17-bit pixel distance plus the fraction bits.
  localparam int unsigned CMP_W = POS_W + 1 + FRAC_BITS + 2;

  logic signed [VEL_V_W:0]    vy_rise;
  logic signed [POS_W:0]      pix_gap;
  logic signed [CMP_W-1:0]    room;
  logic signed [CMP_W-1:0]    neg_room;
  logic signed [CMP_W-1:0]    up_speed;
  logic signed [CMP_W-1:0]    one_px;

  always_comb begin
    vy_rise = (VEL_V_W + 1)'(vy_axis_i);
    if (push_vertical_i == '0) begin
      vy_rise = vy_rise - (VEL_V_W + 1)'(cfg_i.rise_rate);
    end

    pix_gap  = (POS_W + 1)'(position_vertical_i) - (POS_W + 1)'(cfg_i.ceiling_line);
    room     = CMP_W'(pix_gap) <<< FRAC_BITS;
    neg_room = -room;
    up_speed = -CMP_W'(vy_rise);
    one_px   = CMP_W'(1) <<< FRAC_BITS;

    vy_o         = vy_rise[VEL_V_W-1:0];
    surfaced_o   = 1'b0;
    at_ceiling_o = 1'b0;
    if (cfg_i.ceiling_enable && (vy_rise < 0) && (up_speed >= room)) begin
      at_ceiling_o = 1'b1;
      surfaced_o   = (room > 0) && (up_speed > one_px);
      vy_o         = (room > 0) ? neg_room[VEL_V_W-1:0] : '0;
    end
  end

endmodule

// ===== hdl/drag_accel_velocity_step_unit.sv =====
`timescale 1ns / 1ps
// Top level of the drag and acceleration velocity step.
//
// Channels: in_i carries one frame tick per transaction (push signs for both
// axes and the vertical pixel position); out_o returns one transaction per
// tick with the new horizontal and vertical velocities and the surfaced and
// at_ceiling flags. Both use valid/ready; a transaction moves when both are high.
// The configuration port writes register cfg_idx_i with cfg_data_i whenever
// cfg_we_i is high; write it only while no tick is in flight.
// Path: an accepted tick goes to the input register, then through the
// combinational step into the result register, which drives out_o.
// Throughput: one tick per cycle while out_o is not stalled,
// set by the single combinational pass that reads and updates the velocity
// register pair between the two registers.
// Reset (rst_ni low, asynchronous): velocities clear to zero, the configuration
// takes its reset values, both stages empty out; payload is not reset.
// Receiver stall: the result register holds; the input register still takes
// a tick while it is empty, then in_i.ready drops until out_o drains.
module drag_accel_velocity_step_unit #(
  parameter int unsigned FRAC_BITS = dav_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dav_in_if.sink                         in_i,
  dav_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [dav_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dav_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dav_pkg::*;

  cfg_t cfg;

  // Input register.
  logic                     in_valid_q;
  logic signed [PUSH_W-1:0] push_h_q;
  logic signed [PUSH_W-1:0] push_v_q;
  logic signed [POS_W-1:0]  pos_v_q;

  // Velocity state.
  logic signed [VEL_H_W-1:0] vel_h_q, vel_h_d;
  logic signed [VEL_V_W-1:0] vel_v_q, vel_v_d;

  // Result register.
  logic                      out_valid_q;
  logic signed [VEL_H_W-1:0] speed_h_q;
  logic signed [VEL_V_W-1:0] speed_v_q;
  logic                      surfaced_q, surfaced_d;
  logic                      at_ceiling_q, at_ceiling_d;

  logic signed [VEL_H_W-1:0] vy_axis;
  logic                      advance;
  logic                      take_in;

  dav_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dav_axis u_axis_h (
    .v_i       (VEL_V_W'(vel_h_q)),
    .push_i    (push_h_q),
    .current_i (cfg.flow_x),
    .cfg_i     (cfg),
    .v_o       (vel_h_d)
  );

  dav_axis u_axis_v (
    .v_i       (vel_v_q),
    .push_i    (push_v_q),
    .current_i (cfg.flow_y),
    .cfg_i     (cfg),
    .v_o       (vy_axis)
  );

  dav_ceiling #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ceiling (
    .vy_axis_i           (vy_axis),
    .push_vertical_i     (push_v_q),
    .position_vertical_i (pos_v_q),
    .cfg_i               (cfg),
    .vy_o                (vel_v_d),
    .surfaced_o          (surfaced_d),
    .at_ceiling_o        (at_ceiling_d)
  );

  // Advance the held tick when the result register is free or draining.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign take_in  = in_i.valid && in_i.ready;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vel_h_q     <= '0;
      vel_v_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        vel_h_q     <= vel_h_d;
        vel_v_q     <= vel_v_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        // Drop the delivered result.
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      push_h_q <= in_i.push_horizontal;
      push_v_q <= in_i.push_vertical;
      pos_v_q  <= in_i.position_vertical;
    end
    if (advance) begin
      speed_h_q    <= vel_h_d;
      speed_v_q    <= vel_v_d;
      surfaced_q   <= surfaced_d;
      at_ceiling_q <= at_ceiling_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.speed_horizontal = speed_h_q;
  assign out_o.speed_vertical   = speed_v_q;
  assign out_o.surfaced         = surfaced_q;
  assign out_o.at_ceiling       = at_ceiling_q;

endmodule

// ===== hdl/dav_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the result channel, bound to the top level.
module dav_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [dav_pkg::VEL_H_W-1:0]  speed_horizontal,
  input logic signed [dav_pkg::VEL_V_W-1:0]  speed_vertical,
  input logic                                surfaced,
  input logic                                at_ceiling
);
  import dav_pkg::*;

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(speed_horizontal)
      && $stable(speed_vertical) && $stable(surfaced) && $stable(at_ceiling))
    else $error("result changed while stalled");

  // The clamp keeps horizontal speed symmetric.
  a_h_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> speed_horizontal != {1'b1, {(VEL_H_W-1){1'b0}}})
    else $error("horizontal speed outside clamp");

  a_surf_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && surfaced |-> at_ceiling && speed_vertical < 0)
    else $error("surfaced without an upward limited velocity");

  a_top_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && at_ceiling |-> speed_vertical <= 0)
    else $error("top line limit left a downward velocity");

endmodule

bind drag_accel_velocity_step_unit dav_checker u_dav_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid        (out_o.valid),
  .out_ready        (out_o.ready),
  .speed_horizontal (out_o.speed_horizontal),
  .speed_vertical   (out_o.speed_vertical),
  .surfaced         (out_o.surfaced),
  .at_ceiling       (out_o.at_ceiling)
);
